/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked at every rising edge out of reset.
`define ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |-> (c)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (a) |=> (c)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, ck, rn, a, c)
`define ASSERT_NXT(lbl, ck, rn, a, c)

`endif

`endif

/* design/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg
// Types, constants and the FNV-1a fold shared by the page checksum store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int PAGES   = 1024;
  localparam int PAGE_W  = 10;
  localparam int PAGE_AW = $clog2(PAGES);
  localparam int HASH_W  = 64;

  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hCBF2_9CE4_8422_2325;

  typedef enum logic [1:0] {
    ACT_VALIDATE = 2'd0,
    ACT_STORE    = 2'd1,
    ACT_VERIFY   = 2'd2,
    ACT_UPDATE   = 2'd3
  } pcs_action_t;

  typedef struct packed {
    pcs_action_t       action;
    logic [PAGE_W-1:0] page;
    logic [7:0]        data_byte;
    logic              byte_present;
    logic              last_byte;
  } pcs_in_t;

  typedef struct packed {
    logic              ok;
    logic              mismatch;
    logic              created;
    logic [HASH_W-1:0] hash_value;
  } pcs_out_t;

  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] checksum;
  } pcs_entry_t;

  typedef struct packed {
    logic               en;
    logic [PAGE_AW-1:0] addr;
    pcs_entry_t         entry;
  } pcs_tbl_wr_t;

  // The FNV prime is 2^40 + 2^8 + 0xB3, so the product is a sum of shifts.
  function automatic logic [HASH_W-1:0] fnv_mult(input logic [HASH_W-1:0] x);
    fnv_mult = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
  endfunction

  function automatic logic [HASH_W-1:0] fnv_fold(input logic [HASH_W-1:0] h,
                                                 input logic              present,
                                                 input logic [7:0]        b);
    fnv_fold = present ? fnv_mult(h ^ {56'd0, b}) : h;
  endfunction

endpackage

/* design/pcs_table.sv */
// ----------------------------------------------------------------------------
// pcs_table
// Per-page checksum memory with valid marks and a clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcs_table
  import pcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  pcs_tbl_wr_t        wr,
  input  logic               rd_en,
  input  logic [PAGE_AW-1:0] rd_addr,
  output pcs_entry_t         rd_entry,
  output logic               busy
);

  pcs_entry_t         mem [PAGES];
  pcs_entry_t         rd_entry_r;
  logic               clr_busy_r;
  logic               clr_busy_nxt;
  logic [PAGE_AW-1:0] clr_addr_r;
  logic [PAGE_AW-1:0] clr_addr_nxt;

  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == PAGE_AW'(PAGES - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry_r <= mem[rd_addr];
    end
  end

  assign rd_entry = rd_entry_r;
  assign busy     = clr_busy_r;

endmodule

/* design/page_checksum_store_fnv1a.sv */
// ----------------------------------------------------------------------------
// page_checksum_store_fnv1a
// Folds page bytes into a 64-bit FNV-1a hash and checks or stores the result
// in a per-page checksum table on the last byte of each page.
// ----------------------------------------------------------------------------
// The block takes one byte request per clock cycle while in_ready is high. A
// page ends with the request that has last_byte set; its result passes from
// the stage 1 register through the stage 2 register into the output register,
// and requests that are not last give no result. The per-byte rate is set by
// the hash loop, one shift-add constant multiply per cycle. The checksum
// table is a 1024-entry memory that is swept clear after reset; no request is
// accepted during that pass, while configuration writes are taken as usual.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module page_checksum_store_fnv1a
  import pcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  pcs_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output pcs_out_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  logic               enable_r, enable_nxt;
  logic               s1_valid_r, s1_valid_nxt;
  pcs_in_t            s1_r, s1_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [HASH_W-1:0]  s1_fold;
  logic               s2_valid_r, s2_valid_nxt;
  pcs_action_t        s2_act_r, s2_act_nxt;
  logic [PAGE_W-1:0]  s2_page_r, s2_page_nxt;
  logic [HASH_W-1:0]  s2_hash_r, s2_hash_nxt;
  logic               fwd_r, fwd_nxt;
  logic [HASH_W-1:0]  fwd_hash_r, fwd_hash_nxt;
  logic               out_valid_r, out_valid_nxt;
  pcs_out_t           out_r, out_nxt;

  logic               in_acc;
  logic               out_free;
  logic               s2_fire;
  logic               s2_ready;
  logic               s1_adv;
  logic               s2_load;
  logic               tbl_busy;
  pcs_entry_t         tbl_rd;
  pcs_entry_t         entry;
  pcs_tbl_wr_t        tbl_wr;
  logic               in_range;
  logic               same_hash;
  logic               res_ok;
  logic               res_mism;
  logic               res_made;
  logic               res_wen;

  assign out_free = !out_valid_r || out_ready;
  assign s2_fire  = s2_valid_r && out_free;
  assign s2_ready = !s2_valid_r || s2_fire;
  assign s1_adv   = s1_valid_r && (!s1_r.last_byte || s2_ready);
  assign s2_load  = s1_adv && s1_r.last_byte;
  assign in_ready = !tbl_busy && (!s1_valid_r || s1_adv);
  assign in_acc   = in_valid && in_ready;
  assign s1_fold  = fnv_fold(hash_r, s1_r.byte_present, s1_r.data_byte);

  // A write from stage 2 lands on the same edge as the next read,
  // so a read of that page takes the written checksum from the bypass.
  assign entry     = fwd_r ? pcs_entry_t'{valid: 1'b1, checksum: fwd_hash_r} : tbl_rd;
  assign in_range  = 32'(s2_page_r) < PAGES;
  assign same_hash = entry.checksum == s2_hash_r;

  always_comb begin
    res_ok   = 1'b0;
    res_mism = 1'b0;
    res_made = 1'b0;
    res_wen  = 1'b0;
    if (!enable_r) begin
      res_ok = s2_act_r != ACT_STORE;
    end else if (in_range) begin
      case (s2_act_r)
        ACT_VALIDATE: begin
          if (!entry.valid) begin
            res_wen  = 1'b1;
            res_ok   = 1'b1;
            res_made = 1'b1;
          end else begin
            res_ok   = same_hash;
            res_mism = !same_hash;
          end
        end
        ACT_VERIFY: begin
          res_ok = entry.valid && same_hash;
        end
        ACT_STORE, ACT_UPDATE: begin
          res_wen  = 1'b1;
          res_ok   = 1'b1;
          res_made = !entry.valid;
        end
        default: begin
          res_ok = 1'b0;
        end
      endcase
    end
  end

  assign tbl_wr = '{en:    s2_fire && res_wen,
                    addr:  s2_page_r[PAGE_AW-1:0],
                    entry: '{valid: 1'b1, checksum: s2_hash_r}};

  pcs_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (tbl_wr),
    .rd_en    (s2_load),
    .rd_addr  (s1_r.page[PAGE_AW-1:0]),
    .rd_entry (tbl_rd),
    .busy     (tbl_busy)
  );

  always_comb begin
    enable_nxt   = cfg_we ? cfg_wdata : enable_r;

    s1_valid_nxt = s1_valid_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end
    s1_nxt = in_acc ? in_data : s1_r;

    hash_nxt = hash_r;
    if (s1_adv) begin
      hash_nxt = s1_r.last_byte ? FNV_BASIS : s1_fold;
    end

    s2_valid_nxt = s2_valid_r;
    if (s2_fire) begin
      s2_valid_nxt = 1'b0;
    end
    if (s2_load) begin
      s2_valid_nxt = 1'b1;
    end
    s2_act_nxt   = s2_load ? s1_r.action : s2_act_r;
    s2_page_nxt  = s2_load ? s1_r.page : s2_page_r;
    s2_hash_nxt  = s2_load ? s1_fold : s2_hash_r;
    fwd_nxt      = fwd_r;
    fwd_hash_nxt = fwd_hash_r;
    if (s2_load) begin
      fwd_nxt      = tbl_wr.en && (s2_page_r == s1_r.page);
      fwd_hash_nxt = s2_hash_r;
    end

    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (s2_fire) begin
      out_valid_nxt = 1'b1;
    end
    out_nxt = out_r;
    if (s2_fire) begin
      out_nxt = '{ok: res_ok, mismatch: res_mism, created: res_made, hash_value: s2_hash_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      s1_valid_r  <= 1'b0;
      hash_r      <= FNV_BASIS;
      s2_valid_r  <= 1'b0;
      fwd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      enable_r    <= enable_nxt;
      s1_valid_r  <= s1_valid_nxt;
      hash_r      <= hash_nxt;
      s2_valid_r  <= s2_valid_nxt;
      fwd_r       <= fwd_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_r       <= s1_nxt;
    s2_act_r   <= s2_act_nxt;
    s2_page_r  <= s2_page_nxt;
    s2_hash_r  <= s2_hash_nxt;
    fwd_hash_r <= fwd_hash_nxt;
    out_r      <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ASSERT_IMP(a_no_req_while_clearing, clk, rst_n, tbl_busy, !in_ready)
  `ASSERT_IMP(a_no_write_while_clearing, clk, rst_n, tbl_busy, !tbl_wr.en && !s2_valid_r)
  `ASSERT_NXT(a_fire_loads_output, clk, rst_n, s2_fire, out_valid_r)
  `ASSERT_IMP(a_mismatch_not_ok, clk, rst_n, out_valid_r && out_r.mismatch, !out_r.ok && !out_r.created)
  `ASSERT_NXT(a_last_resets_hash, clk, rst_n, s2_load, hash_r == FNV_BASIS)

endmodule
